@@ rtl/core/arp_cache_with_aging_unit_assert.svh @@
// Assertion macros used by the ARP cache datapath.
`ifndef ARP_CACHE_WITH_AGING_UNIT_ASSERT_SVH
`define ARP_CACHE_WITH_AGING_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ARPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/arpc_pkg.sv @@
// Package with types, constants and codes of the ARP cache.
package arpc_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [15:0] TTL_RESET = 16'd60;

    localparam logic [2:0] FN_LEARN   = 3'd0;
    localparam logic [2:0] FN_STATIC  = 3'd1;
    localparam logic [2:0] FN_REFRESH = 3'd2;
    localparam logic [2:0] FN_LOOKUP  = 3'd3;
    localparam logic [2:0] FN_REMOVE  = 3'd4;
    localparam logic [2:0] FN_TICK    = 3'd5;
    localparam logic [2:0] FN_SPARE6  = 3'd6;
    localparam logic [2:0] FN_SPARE7  = 3'd7;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_RSV    = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
    } arpc_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] mac_result;
    } arpc_out_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [15:0] ticks;
        logic        stat;
    } arpc_row_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_ACT,
        S_DONE
    } arpc_state_t;

    typedef struct packed {
        logic start;
        logic scan_en;
        logic act;
        logic load_out;
    } arpc_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } arpc_stat_t;

endpackage

@@ rtl/core/arpc_ctrl.sv @@
// Controller state machine of the ARP cache.
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  arpc_stat_t st,
    output arpc_cmd_t  cmd
);

    arpc_state_t state_reg;
    arpc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (st.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_ACT;
            S_ACT:   state_next = S_DONE;
            S_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            S_SCAN:  cmd.scan_en  = 1'b1;
            S_DRAIN: cmd          = '0;
            S_ACT:   cmd.act      = 1'b1;
            S_DONE:  cmd.load_out = st.out_free;
            default: cmd          = '0;
        endcase
    end

endmodule

@@ rtl/core/arpc_dp.sv @@
// Datapath of the ARP cache: table memory, valid bits, scan and result logic.
`include "arp_cache_with_aging_unit_assert.svh"

module arpc_dp
    import arpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  arpc_in_t    in_data,
    input  logic        cfg_valid,
    input  logic [15:0] cfg_data,
    input  arpc_cmd_t   cmd,
    output arpc_stat_t  st,
    output logic        out_valid,
    input  logic        out_ready,
    output arpc_out_t   out_data
);

    arpc_row_t            mem [ENTRIES];
    arpc_row_t            rd_row_reg;
    logic [ENTRIES-1:0]   valid_reg;
    logic [15:0]          ttl_reg;
    arpc_in_t             item_reg;
    logic [IDX_W-1:0]     scan_cnt_reg;
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [47:0]          hit_mac_reg;
    logic                 hit_stat_reg;
    logic                 free_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    arpc_out_t            res_reg;
    arpc_out_t            res_next;
    logic                 out_valid_reg;
    arpc_out_t            out_reg;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    arpc_row_t            mem_wdata;
    logic                 rd_valid_bit;
    logic                 rd_match;
    logic                 is_tick;
    logic                 tick_drop;
    logic                 tick_dec;
    logic                 act_store;
    logic                 act_new;
    logic                 act_upd;
    logic                 act_remove;

    assign is_tick      = (item_reg.func == FN_TICK);
    assign rd_valid_bit = valid_reg[rd_idx_reg];
    assign rd_match     = rd_valid_bit && (rd_row_reg.ip == item_reg.ip_addr);

    // Aging: a dynamic entry at one tick or less is dropped, others count down.
    assign tick_drop = rd_vld_reg && is_tick && rd_valid_bit && !rd_row_reg.stat
                       && (rd_row_reg.ticks[15:1] == 15'd0);
    assign tick_dec  = rd_vld_reg && is_tick && rd_valid_bit && !rd_row_reg.stat
                       && (rd_row_reg.ticks[15:1] != 15'd0);

    assign act_store  = cmd.act && ((item_reg.func == FN_LEARN) ||
                                    (item_reg.func == FN_STATIC));
    assign act_new    = act_store && !hit_reg && free_reg;
    assign act_upd    = (act_store && hit_reg) ||
                        (cmd.act && (item_reg.func == FN_REFRESH) && hit_reg &&
                         !hit_stat_reg);
    assign act_remove = cmd.act && (item_reg.func == FN_REMOVE) && hit_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = rd_idx_reg;
        mem_wdata = rd_row_reg;
        if (tick_dec)
        begin
            mem_we          = 1'b1;
            mem_wdata.ticks = rd_row_reg.ticks - 16'd1;
        end
        else if (act_new || act_upd)
        begin
            mem_we        = 1'b1;
            mem_waddr     = hit_reg ? hit_idx_reg : free_idx_reg;
            mem_wdata.ip  = item_reg.ip_addr;
            if (item_reg.func == FN_REFRESH)
            begin
                mem_wdata.mac  = hit_mac_reg;
                mem_wdata.stat = 1'b0;
            end
            else
            begin
                mem_wdata.mac  = item_reg.mac_addr;
                mem_wdata.stat = (item_reg.func == FN_STATIC);
            end
            mem_wdata.ticks = mem_wdata.stat ? 16'd0 : ttl_reg;
        end
    end

    always_comb
    begin
        res_next = '{status: ST_OK, mac_result: 48'd0};
        case (item_reg.func)
            FN_LEARN, FN_STATIC:
            begin
                if (!hit_reg && !free_reg)
                begin
                    res_next.status = ST_FULL;
                end
            end
            FN_REFRESH, FN_REMOVE:
            begin
                if (!hit_reg)
                begin
                    res_next.status = ST_ABSENT;
                end
            end
            FN_LOOKUP:
            begin
                if (hit_reg)
                begin
                    res_next.mac_result = hit_mac_reg;
                end
                else
                begin
                    res_next.status = ST_ABSENT;
                end
            end
            default: res_next = '{status: ST_OK, mac_result: 48'd0};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.scan_en)
        begin
            rd_row_reg <= mem[scan_cnt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            item_reg <= in_data;
        end
        if (rd_vld_reg && rd_match && !hit_reg)
        begin
            hit_idx_reg  <= rd_idx_reg;
            hit_mac_reg  <= rd_row_reg.mac;
            hit_stat_reg <= rd_row_reg.stat;
        end
        if (rd_vld_reg && !rd_valid_bit && !free_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.act)
        begin
            res_reg <= res_next;
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            ttl_reg       <= TTL_RESET;
            scan_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                ttl_reg <= cfg_data;
            end
            rd_vld_reg <= cmd.scan_en;
            rd_idx_reg <= scan_cnt_reg;
            if (cmd.start)
            begin
                scan_cnt_reg <= '0;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.scan_en)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (rd_vld_reg && rd_match)
                begin
                    hit_reg <= 1'b1;
                end
                if (rd_vld_reg && !rd_valid_bit)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (tick_drop)
            begin
                valid_reg[rd_idx_reg] <= 1'b0;
            end
            if (act_new)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (act_remove)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign st.scan_last = (scan_cnt_reg == IDX_W'(ENTRIES - 1));
    assign st.out_free  = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;

    `ARPC_ASSERT_NOW(a_load_free, clk, rst_n, cmd.load_out, !out_valid_reg || out_ready, "result loaded over a pending one")
    `ARPC_ASSERT_NXT(a_scan_step, clk, rst_n, cmd.scan_en && !st.scan_last, scan_cnt_reg == $past(scan_cnt_reg) + 1'b1, "scan index skipped")
    `ARPC_ASSERT_NOW(a_status_code, clk, rst_n, out_valid_reg, out_reg.status != ST_RSV, "reserved status code")
    `ARPC_ASSERT_NOW(a_scan_write, clk, rst_n, mem_we && !cmd.act, is_tick, "table written during a scan that is not aging")

endmodule

@@ rtl/core/arp_cache_with_aging_unit.sv @@
// Top level of the ARP cache with TTL aging.
//
//  channel  | signals                     | direction | content
//  ---------+-----------------------------+-----------+------------------------------
//  in       | in_valid, in_ready, in_data | to block  | func, ip_addr, mac_addr
//  out      | out_valid, out_ready,       | from block| status, mac_result
//           | out_data                    |           |
//  cfg      | cfg_valid, cfg_ready,       | to block  | ttl_ticks (always ready)
//           | cfg_data                    |           |
//
// Every item passes the idle state that accepts it, a scan that reads the table
// memory one row per cycle through its single read port, and then the drain,
// action and done states; the done state hands the result to the output register
// once that register is free or being emptied.
// Reset clears the valid bits of all entries at once, so no clearing pass is run.
// A new item is accepted while an earlier result still waits on the output; the
// block holds a finished result internally only if that output register is full.
//
// The controller walks idle, scan, drain, action and done states. During the
// scan the datapath records the first matching valid entry and the first free
// slot, and for an age tick it writes back each dynamic entry with one tick less
// or drops its valid bit. The action cycle then performs the table write, the
// valid-bit change or both that the operation needs and forms the result item.
module arp_cache_with_aging_unit
    import arpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  arpc_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output arpc_out_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    arpc_cmd_t  cmd;
    arpc_stat_t st;

    // The TTL register can be written in any cycle.
    assign cfg_ready = 1'b1;

    arpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    arpc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
